/* rtl/sql_identifier_checker_assert.svh */
// assertion macros for the identifier checker back end
`ifndef SQL_IDENTIFIER_CHECKER_ASSERT_SVH
`define SQL_IDENTIFIER_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SQLID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqlid assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SQLID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqlid assertion failed");

`endif

/* rtl/sqlid_pkg.sv */
// shared types, character constants and helpers for the identifier checker
package sqlid_pkg;

  // parse modes
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_BARE   = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QBS    = 3'd3,
    MODE_CLOSED = 3'd4
  } mode_t;

  // final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_EMPTY_SEG = 3'd2,
    ST_BAD_START = 3'd3,
    ST_BAD_CHAR  = 3'd4,
    ST_UNTERM    = 3'd5
  } status_t;

  // register word index
  typedef enum logic {
    REG_DOT_EN  = 1'b0,
    REG_EMIT_EN = 1'b1
  } reg_idx_t;

  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // results caused by one input transfer: up to three bytes and a status
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_status;
    status_t         status;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == CH_USCORE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

/* rtl/sqlid_front.sv */
// front end: accepts identifier bytes, runs the parser, builds result bundles
module sqlid_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dot_en,
  input  logic               emit_en,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] in_byte
  input  logic               in_tuser,   // [0] no_byte
  input  logic               in_tlast,
  input  logic               q_full,
  output logic               q_push,
  output sqlid_pkg::bundle_t q_data
);

  typedef struct packed {
    sqlid_pkg::mode_t   mode;
    logic               qne;
    sqlid_pkg::status_t err;
    logic               emit;
  } qstep_t;

  // one byte inside backticks
  function automatic qstep_t quoted_step(input logic [7:0] c, input logic qne);
    qstep_t r;
    r.mode = sqlid_pkg::MODE_QUOTED;
    r.qne  = qne;
    r.err  = sqlid_pkg::ST_OK;
    r.emit = 1'b0;
    if (c == sqlid_pkg::CH_BSLASH) begin
      r.mode = sqlid_pkg::MODE_QBS;
    end else if (c == sqlid_pkg::CH_BTICK) begin
      if (!qne) begin
        r.err = sqlid_pkg::ST_EMPTY_SEG;
      end else begin
        r.mode = sqlid_pkg::MODE_CLOSED;
        r.emit = 1'b1;
      end
    end else if (c < sqlid_pkg::CH_SPACE) begin
      r.err = sqlid_pkg::ST_BAD_CHAR;
    end else begin
      r.qne  = 1'b1;
      r.emit = 1'b1;
    end
    return r;
  endfunction

  sqlid_pkg::mode_t   mode_r, mode_nxt;
  logic               dot_r, dot_nxt;
  logic               qne_r, qne_nxt;
  sqlid_pkg::status_t err_r, err_nxt;
  logic [1:0]         nb;
  logic [2:0][7:0]    bs;
  sqlid_pkg::status_t fin_status;
  logic               accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // parser step for the byte on the input
  always_comb begin
    qstep_t q;
    logic   dot_ok;
    q        = '0;
    dot_ok   = 1'b0;
    mode_nxt = mode_r;
    dot_nxt  = dot_r;
    qne_nxt  = qne_r;
    err_nxt  = err_r;
    nb       = 2'd0;
    bs       = '0;
    if (!in_tuser && err_r == sqlid_pkg::ST_OK) begin
      dot_ok = in_tdata == sqlid_pkg::CH_DOT && dot_en && !dot_r;
      unique case (mode_r)
        sqlid_pkg::MODE_START: begin
          if (in_tdata == sqlid_pkg::CH_BTICK) begin
            mode_nxt = sqlid_pkg::MODE_QUOTED;
            qne_nxt  = 1'b0;
            bs[0]    = in_tdata;
            nb       = 2'd1;
          end else if (sqlid_pkg::is_alpha(in_tdata)) begin
            mode_nxt = sqlid_pkg::MODE_BARE;
            bs[0]    = in_tdata;
            nb       = 2'd1;
          end else begin
            err_nxt = sqlid_pkg::ST_BAD_START;
          end
        end
        sqlid_pkg::MODE_BARE: begin
          if (sqlid_pkg::is_alpha(in_tdata) || sqlid_pkg::is_digit(in_tdata)) begin
            bs[0] = in_tdata;
            nb    = 2'd1;
          end else if (dot_ok) begin
            dot_nxt  = 1'b1;
            mode_nxt = sqlid_pkg::MODE_START;
            bs[0]    = in_tdata;
            nb       = 2'd1;
          end else begin
            err_nxt = sqlid_pkg::ST_BAD_CHAR;
          end
        end
        sqlid_pkg::MODE_QUOTED: begin
          q        = quoted_step(in_tdata, qne_r);
          mode_nxt = q.mode;
          qne_nxt  = q.qne;
          if (q.err != sqlid_pkg::ST_OK) begin
            err_nxt = q.err;
          end
          if (q.emit) begin
            bs[0] = in_tdata;
            nb    = 2'd1;
          end
        end
        sqlid_pkg::MODE_QBS: begin
          // pending backslash goes out first, then escape or literal
          qne_nxt  = 1'b1;
          mode_nxt = sqlid_pkg::MODE_QUOTED;
          bs[0]    = sqlid_pkg::CH_BSLASH;
          if (in_tdata == sqlid_pkg::CH_BTICK || in_tdata == sqlid_pkg::CH_BSLASH) begin
            bs[1] = in_tdata;
            nb    = 2'd2;
          end else begin
            bs[1]    = sqlid_pkg::CH_BSLASH;
            q        = quoted_step(in_tdata, 1'b1);
            mode_nxt = q.mode;
            if (q.err != sqlid_pkg::ST_OK) begin
              err_nxt = q.err;
            end
            if (q.emit) begin
              bs[2] = in_tdata;
              nb    = 2'd3;
            end else begin
              nb = 2'd2;
            end
          end
        end
        default: begin
          // after a closing backtick only a dot may follow
          if (dot_ok) begin
            dot_nxt  = 1'b1;
            mode_nxt = sqlid_pkg::MODE_START;
            bs[0]    = in_tdata;
            nb       = 2'd1;
          end else begin
            err_nxt = sqlid_pkg::ST_BAD_CHAR;
          end
        end
      endcase
    end
  end

  // status reported on the last transfer
  always_comb begin
    fin_status = err_nxt;
    if (err_nxt == sqlid_pkg::ST_OK) begin
      unique case (mode_nxt) inside
        sqlid_pkg::MODE_START: begin
          fin_status = dot_nxt ? sqlid_pkg::ST_EMPTY_SEG : sqlid_pkg::ST_EMPTY;
        end
        sqlid_pkg::MODE_BARE, sqlid_pkg::MODE_CLOSED: begin
          fin_status = sqlid_pkg::ST_OK;
        end
        default: begin
          fin_status = sqlid_pkg::ST_UNTERM;
        end
      endcase
    end
  end

  // bundle toward the queue
  always_comb begin
    q_data.nbytes     = emit_en ? nb : 2'd0;
    q_data.bytes      = bs;
    q_data.has_status = in_tlast;
    q_data.status     = fin_status;
    q_push            = accept && ((emit_en && nb != 2'd0) || in_tlast);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sqlid_pkg::MODE_START;
      dot_r  <= 1'b0;
      qne_r  <= 1'b0;
      err_r  <= sqlid_pkg::ST_OK;
    end else if (accept) begin
      if (in_tlast) begin
        mode_r <= sqlid_pkg::MODE_START;
        dot_r  <= 1'b0;
        qne_r  <= 1'b0;
        err_r  <= sqlid_pkg::ST_OK;
      end else begin
        mode_r <= mode_nxt;
        dot_r  <= dot_nxt;
        qne_r  <= qne_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

/* rtl/sqlid_fifo.sv */
// short bundle queue between the front and back ends
module sqlid_fifo #(
  parameter int unsigned DEPTH = sqlid_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sqlid_pkg::bundle_t push_data,
  output logic               full,
  input  logic               pop,
  output sqlid_pkg::bundle_t pop_data,
  output logic               empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  sqlid_pkg::bundle_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r;
  logic               do_push, do_pop;

  assign full     = count_r == CNT_FULL;
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/sqlid_back.sv */
// back end: walks each queued bundle out as one result transfer per cycle while out_tready is high
module sqlid_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sqlid_pkg::bundle_t head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [7:0] out_byte, [10:8] status, rest zero
  output logic               out_tuser,  // [0] kind
  output logic               out_tlast
);

  logic [1:0] idx_r;
  logic [2:0] pos;
  logic [2:0] total;
  logic       is_byte;
  logic       xfer;
  logic [7:0] byte_sel;

  assign pos        = {1'b0, idx_r};
  assign total      = {1'b0, head.nbytes} + {2'b0, head.has_status};
  assign is_byte    = idx_r < head.nbytes;
  assign byte_sel   = head.bytes[idx_r];
  assign out_tvalid = !q_empty;
  assign xfer       = out_tvalid && out_tready;
  assign out_tlast  = pos == total - 3'd1;
  assign q_pop      = xfer && out_tlast;

  // result fields for the current position in the bundle
  always_comb begin
    out_tuser = !is_byte;
    if (is_byte) begin
      out_tdata = {8'h00, byte_sel};
    end else begin
      out_tdata = {5'b0, head.status, 8'h00};
    end
  end

  // position within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (xfer) begin
      idx_r <= out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

`include "sql_identifier_checker_assert.svh"

  `SQLID_ASSERT_IMP(a_no_empty_bundle, out_tvalid, total != 3'd0)
  `SQLID_ASSERT_IMP(a_idx_in_range, out_tvalid, pos < total)
  `SQLID_ASSERT_NXT(a_run_continues, xfer && !out_tlast, out_tvalid && idx_r != 2'd0)
  `SQLID_ASSERT_IMP(a_status_is_last, out_tvalid && out_tuser, out_tlast)

endmodule

/* rtl/sql_identifier_checker.sv */
// identifier checker: accepts one byte per transfer, emits bytes and a final status
// the results of an accepted input transfer are registered in the bundle queue, then offered
// throughput: one input transfer per cycle while each yields at most one result and
// out_tready is high; an input yields up to 4 results, which share the single output port
// a bundle queue of FIFO_DEPTH entries lets input run ahead of a stalled output
// reset: rst_n synchronous active low; parse state cleared, dots allowed, emit_enable=0
module sql_identifier_checker #(
  parameter int unsigned FIFO_DEPTH = sqlid_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] no_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               dot_en_r;
  logic               emit_en_r;
  logic               cfg_wr;
  sqlid_pkg::reg_idx_t cfg_idx;
  logic               q_push, q_full, q_pop, q_empty;
  sqlid_pkg::bundle_t q_in, q_out;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = sqlid_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_en_r  <= 1'b1;
      emit_en_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sqlid_pkg::REG_DOT_EN:  dot_en_r  <= cfg_pwdata[0];
        sqlid_pkg::REG_EMIT_EN: emit_en_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      sqlid_pkg::REG_DOT_EN:  cfg_prdata = {31'b0, dot_en_r};
      sqlid_pkg::REG_EMIT_EN: cfg_prdata = {31'b0, emit_en_r};
      default:                cfg_prdata = 32'b0;
    endcase
  end

  sqlid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .dot_en    (dot_en_r),
    .emit_en   (emit_en_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  sqlid_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sqlid_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/sql_identifier_checker_test.sv */
// self-checking testbench for the streaming sql identifier checker
module sql_identifier_checker_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_AFTER_IN  = 45;
  localparam int PHASE_ITEMS    = 22;

  // checker model and store of awaited results
  class ident_scoreboard;
    typedef struct {
      logic               kind;
      logic [7:0]         data;
      sqlid_pkg::status_t st;
      logic               eor;
    } result_t;

    result_t            awaited_results[$];
    result_t            fresh[$];
    bit                 dot_permit;
    bit                 emit_en;
    sqlid_pkg::mode_t   mode;
    bit                 dot_used;
    bit                 q_nonempty;
    sqlid_pkg::status_t err;
    int                 n_err;

    function new();
      dot_permit = 1'b1;
      emit_en    = 1'b0;
      n_err      = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      mode       = sqlid_pkg::MODE_START;
      dot_used   = 1'b0;
      q_nonempty = 1'b0;
      err        = sqlid_pkg::ST_OK;
    endfunction

    function void set_reg(sqlid_pkg::reg_idx_t idx, bit v);
      case (idx)
        sqlid_pkg::REG_DOT_EN:  dot_permit = v;
        sqlid_pkg::REG_EMIT_EN: emit_en = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void add_result(logic kind, logic [7:0] data, sqlid_pkg::status_t st);
      result_t r;
      r.kind = kind;
      r.data = data;
      r.st   = st;
      r.eor  = 1'b0;
      fresh.insert(fresh.size(), r);
    endfunction

    function void echo(logic [7:0] c);
      if (emit_en) add_result(1'b0, c, sqlid_pkg::ST_OK);
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
             c == sqlid_pkg::CH_USCORE;
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function void dot_or_fail(logic [7:0] c);
      if (c == sqlid_pkg::CH_DOT && dot_permit && !dot_used) begin
        dot_used = 1'b1;
        mode = sqlid_pkg::MODE_START;
        echo(c);
      end else begin
        err = sqlid_pkg::ST_BAD_CHAR;
      end
    endfunction

    // one byte inside backticks, no backslash pending
    function void quoted_byte(logic [7:0] c);
      if (c == sqlid_pkg::CH_BSLASH) begin
        mode = sqlid_pkg::MODE_QBS;
      end else if (c == sqlid_pkg::CH_BTICK) begin
        if (!q_nonempty) begin
          err = sqlid_pkg::ST_EMPTY_SEG;
        end else begin
          mode = sqlid_pkg::MODE_CLOSED;
          echo(c);
        end
      end else if (c < sqlid_pkg::CH_SPACE) begin
        err = sqlid_pkg::ST_BAD_CHAR;
      end else begin
        q_nonempty = 1'b1;
        echo(c);
      end
    endfunction

    function void take_byte(logic [7:0] c);
      case (mode)
        sqlid_pkg::MODE_START: begin
          if (c == sqlid_pkg::CH_BTICK) begin
            mode = sqlid_pkg::MODE_QUOTED;
            q_nonempty = 1'b0;
            echo(c);
          end else if (is_letter(c)) begin
            mode = sqlid_pkg::MODE_BARE;
            echo(c);
          end else begin
            err = sqlid_pkg::ST_BAD_START;
          end
        end
        sqlid_pkg::MODE_BARE: begin
          if (is_letter(c) || is_num(c)) echo(c);
          else dot_or_fail(c);
        end
        sqlid_pkg::MODE_QUOTED: quoted_byte(c);
        sqlid_pkg::MODE_QBS: begin
          // escape pair, or a literal backslash doubled on the way out
          q_nonempty = 1'b1;
          mode = sqlid_pkg::MODE_QUOTED;
          echo(sqlid_pkg::CH_BSLASH);
          if (c == sqlid_pkg::CH_BTICK || c == sqlid_pkg::CH_BSLASH) begin
            echo(c);
          end else begin
            echo(sqlid_pkg::CH_BSLASH);
            quoted_byte(c);
          end
        end
        default: dot_or_fail(c);
      endcase
    endfunction

    function sqlid_pkg::status_t final_status();
      if (err != sqlid_pkg::ST_OK) return err;
      case (mode)
        sqlid_pkg::MODE_START:
          return dot_used ? sqlid_pkg::ST_EMPTY_SEG : sqlid_pkg::ST_EMPTY;
        sqlid_pkg::MODE_BARE,
        sqlid_pkg::MODE_CLOSED: return sqlid_pkg::ST_OK;
        default:                return sqlid_pkg::ST_UNTERM;
      endcase
    endfunction

    // note an accepted input transfer and queue the results it causes
    function void predict_item(logic [7:0] b, logic nb, logic lst);
      fresh.delete();
      if (!nb && err == sqlid_pkg::ST_OK) take_byte(b);
      if (lst) begin
        add_result(1'b1, 8'h00, final_status());
        clear_parse();
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].eor = 1'b1;
      foreach (fresh[i]) awaited_results.insert(awaited_results.size(), fresh[i]);
    endfunction

    // compare an accepted output transfer with the oldest awaited result
    function void check_result(logic kind, logic [7:0] data, logic [2:0] st, logic eor);
      result_t e;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h status %0d", kind, data, st);
        n_err++;
        return;
      end
      e = awaited_results.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, kind);
        n_err++;
      end
      if (data !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, data);
        n_err++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        n_err++;
      end
      if (eor !== e.eor) begin
        $error("end_of_run: expected %0d, got %0d", e.eor, eor);
        n_err++;
      end
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] b;
    logic       nb;
    logic       lst;
  } item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tuser;   // [0] no_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] out_byte, [10:8] status, [15:11] zero
  logic        out_tuser;  // [0] kind
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ident_scoreboard sb = new();
  item_t plan[$];
  int    ident_start = 0;
  int    live_items = 0;
  int    n_in = 0;
  bit    idle_on = 1'b1;

  sql_identifier_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // identifier building
  function automatic void plan_add(logic [7:0] b, logic nb, logic lst);
    item_t it;
    it.b   = b;
    it.nb  = nb;
    it.lst = lst;
    plan.insert(plan.size(), it);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    plan_add(b, 1'b0, 1'b0);
  endfunction

  // random build: an ignored empty transfer slips in now and then
  function automatic void put_byte(logic [7:0] b);
    if ($urandom_range(0, 11) == 0) plan_add(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    add_byte(b);
    live_items++;
  endfunction

  function automatic void end_ident(bit via_empty);
    if (via_empty || plan.size() == ident_start) begin
      plan_add(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      live_items++;
    end else begin
      plan[plan.size() - 1].lst = 1'b1;
    end
    ident_start = plan.size();
  endfunction

  function automatic logic [7:0] bare_char(bit lead);
    int pick;
    pick = $urandom_range(0, lead ? 2 : 3);
    case (pick)
      0:       return 8'($urandom_range(8'h41, 8'h5a));
      1:       return 8'($urandom_range(8'h61, 8'h7a));
      2:       return sqlid_pkg::CH_USCORE;
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  // printable or high byte, never a backslash or backtick
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(8'h80, 8'hff));
    c = 8'($urandom_range(8'h20, 8'h7e));
    if (c == sqlid_pkg::CH_BSLASH || c == sqlid_pkg::CH_BTICK) c = 8'h7e;
    return c;
  endfunction

  function automatic void add_quoted_unit();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      put_byte(plain_char());
    end else if (pick < 16) begin
      put_byte(sqlid_pkg::CH_BSLASH);
      put_byte($urandom_range(0, 1) ? sqlid_pkg::CH_BTICK : sqlid_pkg::CH_BSLASH);
    end else if (pick < 19) begin
      put_byte(sqlid_pkg::CH_BSLASH);
      put_byte(plain_char());
    end else begin
      put_byte(8'($urandom_range(0, 8'h1f)));
    end
  endfunction

  function automatic void add_segment();
    int n;
    if ($urandom_range(0, 1)) begin
      put_byte(bare_char(1'b1));
      n = $urandom_range(0, 5);
      repeat (n) put_byte(bare_char(1'b0));
    end else begin
      put_byte(sqlid_pkg::CH_BTICK);
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      repeat (n) add_quoted_unit();
      if ($urandom_range(0, 9) != 0) put_byte(sqlid_pkg::CH_BTICK);
    end
  endfunction

  // mostly well formed names, some noise, empty names and trailing dots
  function automatic void add_ident();
    int shape;
    shape = $urandom_range(0, 11);
    if (shape == 0) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
    end else if (shape > 1) begin
      add_segment();
      if (shape >= 7) begin
        put_byte(sqlid_pkg::CH_DOT);
        if (shape != 11) add_segment();
      end
    end
    end_ident($urandom_range(0, 4) == 0);
  endfunction

  function automatic void build_random(int target);
    live_items = 0;
    while (live_items < target) add_ident();
  endfunction

  // drive one input transfer and wait until it is taken
  task automatic send_item(input item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.b;
    in_tuser  <= it.nb;
    in_tlast  <= it.lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_item(it.b, it.nb, it.lst);
    n_in++;
  endtask

  // stop input, drain results, let the block settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input sqlid_pkg::reg_idx_t idx, input logic v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {31'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic run_phase(input logic ad, input logic em, input bit idle);
    quiesce();
    write_reg(sqlid_pkg::REG_DOT_EN, ad);
    write_reg(sqlid_pkg::REG_EMIT_EN, em);
    idle_on = idle;
    foreach (plan[i]) send_item(plan[i]);
    plan.delete();
    ident_start = 0;
  endtask

  // main sequence
  initial begin
    logic [1:0] phase_cfg [5];
    phase_cfg = '{2'b11, 2'b01, 2'b10, 2'b00, 2'b11};
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= 1'b0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 3'b000;
    cfg_pwdata  <= 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty name, trailing dot, empty quoted segment
    end_ident(1'b1);
    add_byte(8'h61); add_byte(sqlid_pkg::CH_DOT); end_ident(1'b0);
    add_byte(sqlid_pkg::CH_BTICK); add_byte(sqlid_pkg::CH_BTICK); end_ident(1'b0);
    // escaped backtick, escaped backslash, literal backslash
    add_byte(sqlid_pkg::CH_BTICK);
    add_byte(sqlid_pkg::CH_BSLASH); add_byte(sqlid_pkg::CH_BTICK);
    add_byte(sqlid_pkg::CH_BSLASH); add_byte(sqlid_pkg::CH_BSLASH);
    add_byte(sqlid_pkg::CH_BSLASH); add_byte(8'h7a);
    add_byte(sqlid_pkg::CH_BTICK); end_ident(1'b0);
    // bad start, end right after a backslash, control byte in quotes
    add_byte(8'h39); end_ident(1'b0);
    add_byte(sqlid_pkg::CH_BTICK); add_byte(sqlid_pkg::CH_BSLASH); end_ident(1'b0);
    add_byte(sqlid_pkg::CH_BTICK); add_byte(8'h00); end_ident(1'b0);
    // empty transfers, then a top byte at the start
    add_byte(8'h5a); plan_add(8'hff, 1'b1, 1'b0); end_ident(1'b1);
    add_byte(8'hff); end_ident(1'b0);
    run_phase(1'b1, 1'b1, 1'b1);

    // dot refused
    add_byte(8'h61); add_byte(sqlid_pkg::CH_DOT); add_byte(8'h62); end_ident(1'b0);
    run_phase(1'b0, 1'b1, 1'b1);

    // random names over several settings, no idling in the last one
    for (int p = 0; p < 5; p++) begin
      build_random(PHASE_ITEMS);
      run_phase(phase_cfg[p][1], phase_cfg[p][0], p != 4);
    end

    quiesce();
    repeat (10) @(posedge clk);
    if (sb.n_err == 0) begin
      $display("sql_identifier_checker_test: done, clean");
    end else begin
      $display("sql_identifier_checker_test: done, errors");
    end
    $finish;
  end

  // result side ready, with idle bursts and one long hold-off
  initial begin
    int  burst;
    bit  held;
    held = 1'b0;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && n_in >= HOLD_AFTER_IN) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        burst = $urandom_range(1, 10);
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[7:0], out_tdata[10:8], out_tlast);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
      else quiet++;
    end
    $display("sql_identifier_checker_test: done, errors");
    $finish;
  end

endmodule
